// File: hdl/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// shared constants and types of the bandpass gain correction unit
// ----------------------------------------------------------------------------
package bgc_pkg;

   localparam int MAX_TABLE_CHANNELS = 1024;
   localparam int SAMPLE_WIDTH       = 16;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   typedef enum logic [1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_SAMPLE = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_BYPASS  = 2'd0,
      ST_APPLIED = 2'd1,
      ST_RANGE   = 2'd2,
      ST_RSVD    = 2'd3
   } status_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OFFSET_A   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_STEP_A     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SIZE_A     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OFFSET_B   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_STEP_B     = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SIZE_B     = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_APPLY_MASK = 3'd6;

endpackage

// File: hdl/bandpass_gain_correction_unit.sv
// ----------------------------------------------------------------------------
// bandpass_gain_correction_unit
// applies smoothed complex bandpass gains from two tables to spectrum samples
// ----------------------------------------------------------------------------
// req_ carries load items for tables a and b and spectrum samples; tuser is
// the command. rsp_ returns one item per sample, none for loads. csr_ writes
// the mapping registers and the apply mask; the user must do so only while the
// block is idle, as the block itself does not enforce it. A sample passes
// a seven stage pipeline: multiply by step, offset and range check, three
// parallel table reads per table, smoothing, gain product, sample product,
// round and saturate; one item is accepted every cycle unless the pipeline halts.
// The whole pipeline advances together and halts when rsp_tvalid is high and
// rsp_tready is low, so req_tready falls only then; nothing is lost.
// Reset clears the pipeline valid bits and sets the registers to their
// defaults; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module bandpass_gain_correction_unit #(
   parameter int MAX_TABLE_CHANNELS = bgc_pkg::MAX_TABLE_CHANNELS,
   parameter int SAMPLE_WIDTH       = bgc_pkg::SAMPLE_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // channel, data_re, data_im
   input  logic [1:0]  req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_re, out_im, status, saturated, zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic signed [31:0] offset_a_ff, offset_b_ff;
   logic [31:0] step_a_ff, step_b_ff;
   logic [10:0] size_a_ff, size_b_ff;
   logic [1:0]  mask_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_a_ff <= '0;
         offset_b_ff <= '0;
         step_a_ff   <= 32'd65536;
         step_b_ff   <= 32'd65536;
         size_a_ff   <= 11'd1024;
         size_b_ff   <= 11'd1024;
         mask_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            bgc_pkg::REG_OFFSET_A:   offset_a_ff <= csr_data;
            bgc_pkg::REG_STEP_A:     step_a_ff   <= csr_data;
            bgc_pkg::REG_SIZE_A:     size_a_ff   <= csr_data[10:0];
            bgc_pkg::REG_OFFSET_B:   offset_b_ff <= csr_data;
            bgc_pkg::REG_STEP_B:     step_b_ff   <= csr_data;
            bgc_pkg::REG_SIZE_B:     size_b_ff   <= csr_data[10:0];
            bgc_pkg::REG_APPLY_MASK: mask_ff     <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   logic adv, out_valid, out_sat;
   logic signed [15:0] out_re, out_im;
   logic [1:0] out_status;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   bgc_datapath #(
      .MAX_TABLE_CHANNELS(MAX_TABLE_CHANNELS),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_datapath (
      .clock,
      .reset,
      .adv,
      .in_valid(req_tvalid),
      .in_cmd(req_tuser),
      .in_chan(req_tdata[15:0]),
      .in_re(req_tdata[31:16]),
      .in_im(req_tdata[47:32]),
      .offset_a(offset_a_ff),
      .step_a(step_a_ff),
      .size_a(size_a_ff),
      .offset_b(offset_b_ff),
      .step_b(step_b_ff),
      .size_b(size_b_ff),
      .apply_mask(mask_ff),
      .out_valid,
      .out_re,
      .out_im,
      .out_status,
      .out_sat
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {5'b0, out_sat, out_status, out_im, out_re};

endmodule

// File: hdl/bgc_ram.sv
// ----------------------------------------------------------------------------
// bgc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bgc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/bgc_datapath.sv
// ----------------------------------------------------------------------------
// bgc_datapath
// mapping, table reads, smoothing, complex products, rounding, saturation
// ----------------------------------------------------------------------------
module bgc_datapath #(
   parameter int MAX_TABLE_CHANNELS = bgc_pkg::MAX_TABLE_CHANNELS,
   parameter int SAMPLE_WIDTH       = bgc_pkg::SAMPLE_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [1:0]          in_cmd,
   input  logic [15:0]         in_chan,
   input  logic signed [15:0]  in_re,
   input  logic signed [15:0]  in_im,
   input  logic signed [31:0]  offset_a,
   input  logic [31:0]         step_a,
   input  logic [10:0]         size_a,
   input  logic signed [31:0]  offset_b,
   input  logic [31:0]         step_b,
   input  logic [10:0]         size_b,
   input  logic [1:0]          apply_mask,
   output logic                out_valid,
   output logic signed [15:0]  out_re,
   output logic signed [15:0]  out_im,
   output logic [1:0]          out_status,
   output logic                out_sat
);

   localparam int AW = $clog2(MAX_TABLE_CHANNELS);
   localparam int SW = $clog2(MAX_TABLE_CHANNELS + 1);
   localparam int SATB = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;

   // effective sizes
   logic [SW-1:0] eff_a, eff_b;
   function automatic logic [SW-1:0] clamp_size(input logic [10:0] s);
      logic [16:0] w;
      w = 17'(s);
      if (w < 17'd2) return SW'(2);
      if (w > 17'(MAX_TABLE_CHANNELS)) return SW'(MAX_TABLE_CHANNELS);
      return SW'(w);
   endfunction
   assign eff_a = clamp_size(size_a);
   assign eff_b = clamp_size(size_b);

   logic in_chan_ok;
   assign in_chan_ok = 32'(in_chan) < 32'(MAX_TABLE_CHANNELS);

   // ---------------- stage 1: channel times step (two multipliers)
   logic s1_v_ff, s1_load_a_ff, s1_load_b_ff;
   logic [47:0] s1_pa_ff, s1_pb_ff;
   logic [15:0] s1_chan_ff;
   logic signed [15:0] s1_re_ff, s1_im_ff;
   logic s1_v_in;

   assign s1_v_in = in_valid && (in_cmd == bgc_pkg::CMD_SAMPLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s1_load_a_ff <= 1'b0;
         s1_load_b_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff      <= s1_v_in;
         s1_load_a_ff <= in_valid && (in_cmd == bgc_pkg::CMD_LOAD_A) && in_chan_ok;
         s1_load_b_ff <= in_valid && (in_cmd == bgc_pkg::CMD_LOAD_B) && in_chan_ok;
      end
      if (adv) begin
         s1_pa_ff   <= 48'(in_chan) * 48'(step_a);
         s1_pb_ff   <= 48'(in_chan) * 48'(step_b);
         s1_chan_ff <= in_chan;
         s1_re_ff   <= in_re;
         s1_im_ff   <= in_im;
      end
   end

   // table writes leave stage 1, so a later load never overtakes a sample's read
   logic wr_a, wr_b;
   assign wr_a = adv && s1_load_a_ff;
   assign wr_b = adv && s1_load_b_ff;

   // ---------------- stage 2: add offset, round, range check, neighbor addresses
   logic signed [49:0] pos_a, pos_b;
   assign pos_a = 50'(offset_a) + $signed({2'b0, s1_pa_ff}) + 50'sh8000;
   assign pos_b = 50'(offset_b) + $signed({2'b0, s1_pb_ff}) + 50'sh8000;

   logic ok_a, ok_b;
   logic [33:0] ch_a, ch_b;
   assign ch_a = pos_a[49:16];
   assign ch_b = pos_b[49:16];
   assign ok_a = !pos_a[49] && (ch_a < 34'(eff_a));
   assign ok_b = !pos_b[49] && (ch_b < 34'(eff_b));

   logic s2_v_ff, s2_bad_ff, s2_edge_a_ff, s2_edge_b_ff;
   logic [AW-1:0] s2_lo_a_ff, s2_lo_b_ff;
   logic signed [15:0] s2_re_ff, s2_im_ff;
   logic [1:0] s2_mask_ff;

   logic [AW-1:0] lo_a_in, lo_b_in;
   logic edge_a_in, edge_b_in;
   always_comb begin
      edge_a_in = (ch_a == 34'd0) || (ch_a == 34'(eff_a) - 34'd1);
      edge_b_in = (ch_b == 34'd0) || (ch_b == 34'(eff_b) - 34'd1);
      if (ch_a == 34'd0) lo_a_in = '0;
      else if (edge_a_in) lo_a_in = AW'(34'(eff_a) - 34'd2);
      else lo_a_in = AW'(ch_a - 34'd1);
      if (ch_b == 34'd0) lo_b_in = '0;
      else if (edge_b_in) lo_b_in = AW'(34'(eff_b) - 34'd2);
      else lo_b_in = AW'(ch_b - 34'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
      if (adv) begin
         s2_bad_ff    <= (apply_mask[0] && !ok_a) || (apply_mask[1] && !ok_b);
         s2_edge_a_ff <= edge_a_in;
         s2_edge_b_ff <= edge_b_in;
         s2_lo_a_ff   <= lo_a_in;
         s2_lo_b_ff   <= lo_b_in;
         s2_re_ff     <= s1_re_ff;
         s2_im_ff     <= s1_im_ff;
         s2_mask_ff   <= apply_mask;
      end
   end

   // three table copies per table give three reads in one cycle
   logic [31:0] ra0, ra1, ra2, rb0, rb1, rb2;
   logic [AW-1:0] wr_addr;
   logic [31:0] wr_word;
   assign wr_addr = AW'(s1_chan_ff);
   assign wr_word = {s1_im_ff, s1_re_ff};

   logic [AW-1:0] a1, a2, b1, b2;
   assign a1 = s2_lo_a_ff + AW'(1);
   assign a2 = s2_lo_a_ff + AW'(2);
   assign b1 = s2_lo_b_ff + AW'(1);
   assign b2 = s2_lo_b_ff + AW'(2);

   bgc_ram #(.WIDTH(32), .DEPTH(MAX_TABLE_CHANNELS)) u_ram_a0 (.clock, .wr_en(wr_a),
      .wr_addr, .wr_data(wr_word), .rd_en(adv), .rd_addr(s2_lo_a_ff), .rd_data(ra0));
   bgc_ram #(.WIDTH(32), .DEPTH(MAX_TABLE_CHANNELS)) u_ram_a1 (.clock, .wr_en(wr_a),
      .wr_addr, .wr_data(wr_word), .rd_en(adv), .rd_addr(a1), .rd_data(ra1));
   bgc_ram #(.WIDTH(32), .DEPTH(MAX_TABLE_CHANNELS)) u_ram_a2 (.clock, .wr_en(wr_a),
      .wr_addr, .wr_data(wr_word), .rd_en(adv), .rd_addr(a2), .rd_data(ra2));
   bgc_ram #(.WIDTH(32), .DEPTH(MAX_TABLE_CHANNELS)) u_ram_b0 (.clock, .wr_en(wr_b),
      .wr_addr, .wr_data(wr_word), .rd_en(adv), .rd_addr(s2_lo_b_ff), .rd_data(rb0));
   bgc_ram #(.WIDTH(32), .DEPTH(MAX_TABLE_CHANNELS)) u_ram_b1 (.clock, .wr_en(wr_b),
      .wr_addr, .wr_data(wr_word), .rd_en(adv), .rd_addr(b1), .rd_data(rb1));
   bgc_ram #(.WIDTH(32), .DEPTH(MAX_TABLE_CHANNELS)) u_ram_b2 (.clock, .wr_en(wr_b),
      .wr_addr, .wr_data(wr_word), .rd_en(adv), .rd_addr(b2), .rd_data(rb2));

   // ---------------- stage 3: ram outputs valid, carried control
   logic s3_v_ff, s3_bad_ff, s3_edge_a_ff, s3_edge_b_ff;
   logic signed [15:0] s3_re_ff, s3_im_ff;
   logic [1:0] s3_mask_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
      if (adv) begin
         s3_bad_ff    <= s2_bad_ff;
         s3_edge_a_ff <= s2_edge_a_ff;
         s3_edge_b_ff <= s2_edge_b_ff;
         s3_re_ff     <= s2_re_ff;
         s3_im_ff     <= s2_im_ff;
         s3_mask_ff   <= s2_mask_ff;
      end
   end

   // smoothing, 16 fraction bits, 19 bit result
   function automatic logic signed [18:0] smooth(input logic edge_sel,
      input logic signed [15:0] e0, input logic signed [15:0] e1,
      input logic signed [15:0] e2);
      if (edge_sel) return 19'sd2 * (19'(e0) + 19'(e1));
      return 19'(e0) + 19'sd2 * 19'(e1) + 19'(e2);
   endfunction

   logic signed [18:0] gar, gai, gbr, gbi;
   logic edge_a_lo, edge_b_lo;
   assign edge_a_lo = s3_edge_a_ff;
   assign edge_b_lo = s3_edge_b_ff;
   assign gar = smooth(edge_a_lo, ra0[15:0], ra1[15:0], ra2[15:0]);
   assign gai = smooth(edge_a_lo, ra0[31:16], ra1[31:16], ra2[31:16]);
   assign gbr = smooth(edge_b_lo, rb0[15:0], rb1[15:0], rb2[15:0]);
   assign gbi = smooth(edge_b_lo, rb0[31:16], rb1[31:16], rb2[31:16]);

   // ---------------- stage 4: smoothed gains registered
   logic s4_v_ff, s4_bad_ff;
   logic signed [18:0] s4_gar_ff, s4_gai_ff, s4_gbr_ff, s4_gbi_ff;
   logic signed [15:0] s4_re_ff, s4_im_ff;
   logic [1:0] s4_mask_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s4_v_ff <= s3_v_ff;
      end
      if (adv) begin
         s4_bad_ff  <= s3_bad_ff;
         s4_gar_ff  <= gar;
         s4_gai_ff  <= gai;
         s4_gbr_ff  <= gbr;
         s4_gbi_ff  <= gbi;
         s4_re_ff   <= s3_re_ff;
         s4_im_ff   <= s3_im_ff;
         s4_mask_ff <= s3_mask_ff;
      end
   end

   // ---------------- stage 5: gain g = gA * conj(gB), or gA or conj(gB) alone
   // combined gain has 32 fraction bits with both tables
   logic signed [38:0] ggr_in, ggi_in;
   always_comb begin
      unique case (s4_mask_ff)
         2'b11: begin
            ggr_in = 39'(s4_gar_ff) * 39'(s4_gbr_ff) + 39'(s4_gai_ff) * 39'(s4_gbi_ff);
            ggi_in = 39'(s4_gai_ff) * 39'(s4_gbr_ff) - 39'(s4_gar_ff) * 39'(s4_gbi_ff);
         end
         2'b01: begin
            ggr_in = 39'(s4_gar_ff);
            ggi_in = 39'(s4_gai_ff);
         end
         2'b10: begin
            ggr_in = 39'(s4_gbr_ff);
            ggi_in = -39'(s4_gbi_ff);
         end
         default: begin
            ggr_in = '0;
            ggi_in = '0;
         end
      endcase
   end

   logic s5_v_ff, s5_bad_ff;
   logic signed [38:0] s5_gr_ff, s5_gi_ff;
   logic signed [15:0] s5_re_ff, s5_im_ff;
   logic [1:0] s5_mask_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (adv) begin
         s5_v_ff <= s4_v_ff;
      end
      if (adv) begin
         s5_bad_ff  <= s4_bad_ff;
         s5_gr_ff   <= ggr_in;
         s5_gi_ff   <= ggi_in;
         s5_re_ff   <= s4_re_ff;
         s5_im_ff   <= s4_im_ff;
         s5_mask_ff <= s4_mask_ff;
      end
   end

   // ---------------- stage 6: sample times gain, four partial products
   logic signed [55:0] p_rr, p_ii, p_ri, p_ir;
   assign p_rr = 56'(s5_re_ff) * 56'(s5_gr_ff);
   assign p_ii = 56'(s5_im_ff) * 56'(s5_gi_ff);
   assign p_ri = 56'(s5_re_ff) * 56'(s5_gi_ff);
   assign p_ir = 56'(s5_im_ff) * 56'(s5_gr_ff);

   logic s6_v_ff, s6_bad_ff;
   logic signed [55:0] s6_rr_ff, s6_ii_ff, s6_ri_ff, s6_ir_ff;
   logic signed [15:0] s6_re_ff, s6_im_ff;
   logic [1:0] s6_mask_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (adv) begin
         s6_v_ff <= s5_v_ff;
      end
      if (adv) begin
         s6_bad_ff  <= s5_bad_ff;
         s6_rr_ff   <= p_rr;
         s6_ii_ff   <= p_ii;
         s6_ri_ff   <= p_ri;
         s6_ir_ff   <= p_ir;
         s6_re_ff   <= s5_re_ff;
         s6_im_ff   <= s5_im_ff;
         s6_mask_ff <= s5_mask_ff;
      end
   end

   // ---------------- stage 7: sum, round, saturate
   logic signed [56:0] yr, yi, rr, ri;
   logic signed [56:0] sat_hi, sat_lo;
   logic signed [56:0] vr, vi;
   logic [1:0] st;
   logic clip_r, clip_i;
   logic signed [15:0] o_re, o_im;
   always_comb begin
      yr = 57'(s6_rr_ff) - 57'(s6_ii_ff);
      yi = 57'(s6_ri_ff) + 57'(s6_ir_ff);
      if (s6_mask_ff == 2'b11) begin
         rr = (yr + 57'sd2147483648) >>> 32;
         ri = (yi + 57'sd2147483648) >>> 32;
      end else begin
         rr = (yr + 57'sd32768) >>> 16;
         ri = (yi + 57'sd32768) >>> 16;
      end
      if (s6_mask_ff == 2'b00) begin
         st = bgc_pkg::ST_BYPASS;
         vr = 57'(s6_re_ff);
         vi = 57'(s6_im_ff);
      end else if (s6_bad_ff) begin
         st = bgc_pkg::ST_RANGE;
         vr = 57'(s6_re_ff);
         vi = 57'(s6_im_ff);
      end else begin
         st = bgc_pkg::ST_APPLIED;
         vr = rr;
         vi = ri;
      end
      sat_hi = (57'sd1 <<< (SATB - 1)) - 57'sd1;
      sat_lo = -sat_hi - 57'sd1;
      clip_r = (vr > sat_hi) || (vr < sat_lo);
      clip_i = (vi > sat_hi) || (vi < sat_lo);
      o_re = (vr > sat_hi) ? 16'(sat_hi) : (vr < sat_lo) ? 16'(sat_lo) : 16'(vr);
      o_im = (vi > sat_hi) ? 16'(sat_hi) : (vi < sat_lo) ? 16'(sat_lo) : 16'(vi);
   end

   logic s7_v_ff, s7_sat_ff;
   logic signed [15:0] s7_re_ff, s7_im_ff;
   logic [1:0] s7_st_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else if (adv) begin
         s7_v_ff <= s6_v_ff;
      end
      if (adv) begin
         s7_re_ff  <= o_re;
         s7_im_ff  <= o_im;
         s7_st_ff  <= st;
         s7_sat_ff <= clip_r || clip_i;
      end
   end

   assign out_valid  = s7_v_ff;
   assign out_re     = s7_re_ff;
   assign out_im     = s7_im_ff;
   assign out_status = s7_st_ff;
   assign out_sat    = s7_sat_ff;

`ifndef ASSERT_OFF
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_status != bgc_pkg::ST_RSVD))
      else $error("reserved status code");
   a_bypass_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_status == bgc_pkg::ST_BYPASS && SATB == 16) |-> !out_sat)
      else $error("bypass item reported clipping");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!adv && out_valid) |=> (out_valid && $stable(out_re) && $stable(out_im)))
      else $error("stalled result changed");
`endif

endmodule

// File: dv/bandpass_gain_correction_unit_tb.sv
// ----------------------------------------------------------------------------
// bandpass_gain_correction_unit_tb
// fills the low entries and top pair of both gain tables, then streams loads and
// spectrum samples through several register settings; a local predictor computes
// the smoothed gain product per sample and each rsp item is compared field by field
// ----------------------------------------------------------------------------
module bandpass_gain_correction_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FILL_CHANNELS = 48;
   localparam logic [2:0] REG_UNKNOWN = 3'd7;

   typedef struct packed {
      bgc_pkg::cmd_type cmd;
      logic [15:0]      chan;
      logic [15:0]      re;
      logic [15:0]      im;
   } req_item_t;

   typedef struct packed {
      logic [15:0]         re;
      logic [15:0]         im;
      bgc_pkg::status_type status;
      logic                sat;
   } rsp_item_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // channel, data_re, data_im
   logic [1:0]  req_tuser = '0;   // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // out_re, out_im, status, saturated, zero fill
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   bandpass_gain_correction_unit dut (.*);

   req_item_t   pending_items[$];
   rsp_item_t   expected_samples[$];
   req_item_t   cur_item = '0;
   logic [31:0] gains_a[bgc_pkg::MAX_TABLE_CHANNELS];
   logic [31:0] gains_b[bgc_pkg::MAX_TABLE_CHANNELS];
   longint      offs_a = 0, offs_b = 0;
   longint      stp_a = 65536, stp_b = 65536, sz_a = 1024, sz_b = 1024;
   logic [1:0]  mask = 2'd0;
   int          errors = 0;
   int          cycle = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          rsp_count = 0;

   initial forever #2 clock = ~clock;

   initial begin
      #1ms;
      $display("bandpass_gain_correction_unit: mismatch");
      $finish;
   end

   function automatic bit map_chan(longint off, longint stp, longint sz, longint ch,
                                   output longint c, output longint n);
      longint pos;
      pos = off + ch * stp + 64'h8000;
      n = (sz < 2) ? 2 : (sz > bgc_pkg::MAX_TABLE_CHANNELS) ? bgc_pkg::MAX_TABLE_CHANNELS : sz;
      c = 0;
      if (pos < 0) return 1'b0;
      pos = pos >>> 16;
      if (pos >= n) return 1'b0;
      c = pos;
      return 1'b1;
   endfunction

   function automatic void smoothed_gain(bit use_b, longint c, longint n,
                                         output longint gr, output longint gi);
      logic [31:0] e0, e1, e2;
      longint lo;
      if (c == 0 || c == n - 1) begin
         lo = (c == 0) ? 0 : n - 2;
         e0 = use_b ? gains_b[lo] : gains_a[lo];
         e1 = use_b ? gains_b[lo + 1] : gains_a[lo + 1];
         gr = 2 * (longint'($signed(e0[15:0])) + longint'($signed(e1[15:0])));
         gi = 2 * (longint'($signed(e0[31:16])) + longint'($signed(e1[31:16])));
      end else begin
         e0 = use_b ? gains_b[c - 1] : gains_a[c - 1];
         e1 = use_b ? gains_b[c] : gains_a[c];
         e2 = use_b ? gains_b[c + 1] : gains_a[c + 1];
         gr = longint'($signed(e0[15:0])) + 2 * longint'($signed(e1[15:0]))
              + longint'($signed(e2[15:0]));
         gi = longint'($signed(e0[31:16])) + 2 * longint'($signed(e1[31:16]))
              + longint'($signed(e2[31:16]));
      end
   endfunction

   function automatic longint clip16(longint x, ref bit sat);
      if (x > 32767) begin sat = 1'b1; return 32767; end
      if (x < -32768) begin sat = 1'b1; return -32768; end
      return x;
   endfunction

   function automatic void predict_correction(req_item_t it);
      longint yr, yi, tr, ti, gr, gi, ca, na, cb, nb;
      int frac;
      bit ok, sat;
      rsp_item_t r;
      if (it.cmd == bgc_pkg::CMD_LOAD_A || it.cmd == bgc_pkg::CMD_LOAD_B) begin
         if (it.chan < bgc_pkg::MAX_TABLE_CHANNELS) begin
            if (it.cmd == bgc_pkg::CMD_LOAD_A) gains_a[it.chan] = {it.im, it.re};
            else gains_b[it.chan] = {it.im, it.re};
         end
         return;
      end
      if (it.cmd != bgc_pkg::CMD_SAMPLE) return;
      yr = longint'($signed(it.re));
      yi = longint'($signed(it.im));
      frac = 0;
      sat = 1'b0;
      r.status = bgc_pkg::ST_BYPASS;
      if (mask != 2'd0) begin
         ok = 1'b1;
         if (mask[0] && !map_chan(offs_a, stp_a, sz_a, it.chan, ca, na)) ok = 1'b0;
         if (mask[1] && !map_chan(offs_b, stp_b, sz_b, it.chan, cb, nb)) ok = 1'b0;
         if (!ok) r.status = bgc_pkg::ST_RANGE;
         else begin
            r.status = bgc_pkg::ST_APPLIED;
            if (mask[0]) begin
               smoothed_gain(1'b0, ca, na, gr, gi);
               tr = yr * gr - yi * gi;
               ti = yr * gi + yi * gr;
               yr = tr; yi = ti; frac += 16;
            end
            if (mask[1]) begin
               smoothed_gain(1'b1, cb, nb, gr, gi);
               tr = yr * gr + yi * gi;
               ti = yi * gr - yr * gi;
               yr = tr; yi = ti; frac += 16;
            end
            yr = (yr + (64'sd1 <<< (frac - 1))) >>> frac;
            yi = (yi + (64'sd1 <<< (frac - 1))) >>> frac;
         end
      end
      r.re = 16'(clip16(yr, sat));
      r.im = 16'(clip16(yi, sat));
      r.sat = sat;
      expected_samples.push_back(r);
   endfunction

   function automatic bit quiet_stretch();
      return cycle > 300 && cycle < 700;
   endfunction

   // driver
   always @(posedge clock) begin
      req_item_t nxt;
      bit        busy;
      cycle <= cycle + 1;
      if (!reset) begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_correction(cur_item);
            busy = 1'b0;
         end
         if (!busy) begin
            if (pending_items.size() != 0 && (quiet_stretch() || $urandom_range(99) >= 16)) begin
               nxt = pending_items.pop_front();
               cur_item <= nxt;
               req_tdata <= {nxt.im, nxt.re, nxt.chan};
               req_tuser <= nxt.cmd;
               req_tvalid <= 1'b1;
            end else
               req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_t got, want;
      int        hold;
      if (!reset) begin
         hold = hold_left;
         if (rsp_tvalid && rsp_tready) begin
            got.re = rsp_tdata[15:0];
            got.im = rsp_tdata[31:16];
            got.status = bgc_pkg::status_type'(rsp_tdata[33:32]);
            got.sat = rsp_tdata[34];
            rsp_count++;
            if (expected_samples.size() == 0) begin
               errors++;
               $display("%0t unexpected rsp item %h", $time, got);
            end else begin
               want = expected_samples.pop_front();
               if (got.re !== want.re || got.im !== want.im || got.status !== want.status
                   || got.sat !== want.sat) begin
                  errors++;
                  $display("%0t expected re %h im %h st %0d sat %b, got re %h im %h st %0d sat %b",
                           $time, want.re, want.im, want.status, want.sat,
                           got.re, got.im, got.status, got.sat);
               end
            end
            if (rsp_count >= 100 && !hold_done && pending_items.size() > 30) begin
               hold = 250;
               hold_done = 1'b1;
            end
         end
         if (hold > 0) begin
            hold_left <= hold - 1;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= quiet_stretch() || $urandom_range(99) >= 16;
      end
   end

   task automatic send(bgc_pkg::cmd_type cmd, int chan, int re, int im);
      req_item_t it;
      it.cmd = cmd;
      it.chan = 16'(chan);
      it.re = 16'(re);
      it.im = 16'(im);
      pending_items.push_back(it);
   endtask

   task automatic drain(int tail);
      do @(negedge clock); while (pending_items.size() != 0 || req_tvalid);
      do @(negedge clock); while (expected_samples.size() != 0);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         bgc_pkg::REG_OFFSET_A:   offs_a = longint'($signed(val));
         bgc_pkg::REG_STEP_A:     stp_a = longint'(val);
         bgc_pkg::REG_SIZE_A:     sz_a = longint'(val[10:0]);
         bgc_pkg::REG_OFFSET_B:   offs_b = longint'($signed(val));
         bgc_pkg::REG_STEP_B:     stp_b = longint'(val);
         bgc_pkg::REG_SIZE_B:     sz_b = longint'(val[10:0]);
         bgc_pkg::REG_APPLY_MASK: mask = val[1:0];
         default: ;
      endcase
   endtask

   task automatic set_mapping(logic [31:0] oa, logic [31:0] sa, logic [31:0] za,
                              logic [31:0] ob, logic [31:0] sb, logic [31:0] zb,
                              logic [31:0] m);
      write_reg(bgc_pkg::REG_OFFSET_A, oa);
      write_reg(bgc_pkg::REG_STEP_A, sa);
      write_reg(bgc_pkg::REG_SIZE_A, za);
      write_reg(bgc_pkg::REG_OFFSET_B, ob);
      write_reg(bgc_pkg::REG_STEP_B, sb);
      write_reg(bgc_pkg::REG_SIZE_B, zb);
      write_reg(bgc_pkg::REG_APPLY_MASK, m);
   endtask

   task automatic random_items(int count, int chan_hi);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 72)
            send(bgc_pkg::CMD_SAMPLE, ($urandom_range(4) == 0) ? $urandom_range(65535)
                 : $urandom_range(chan_hi), $urandom, $urandom);
         else if (r < 84)
            send(bgc_pkg::CMD_LOAD_A, ($urandom_range(9) == 0) ? $urandom_range(65535)
                 : $urandom_range(bgc_pkg::MAX_TABLE_CHANNELS - 1), $urandom, $urandom);
         else if (r < 96)
            send(bgc_pkg::CMD_LOAD_B, ($urandom_range(9) == 0) ? $urandom_range(65535)
                 : $urandom_range(bgc_pkg::MAX_TABLE_CHANNELS - 1), $urandom, $urandom);
         else
            send(bgc_pkg::CMD_UNUSED, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // fill the low entries and the top pair of both tables; every mapping
      // below keeps in-range samples on these entries
      for (int c = 0; c < FILL_CHANNELS; c++) begin
         send(bgc_pkg::CMD_LOAD_A, c, $urandom_range(32767, 8192), $urandom_range(4095));
         send(bgc_pkg::CMD_LOAD_B, c, $urandom_range(32767, 8192), $urandom_range(4095));
      end
      for (int c = bgc_pkg::MAX_TABLE_CHANNELS - 2; c < bgc_pkg::MAX_TABLE_CHANNELS; c++) begin
         send(bgc_pkg::CMD_LOAD_A, c, $urandom_range(32767, 8192), $urandom_range(4095));
         send(bgc_pkg::CMD_LOAD_B, c, $urandom_range(32767, 8192), $urandom_range(4095));
      end
      send(bgc_pkg::CMD_SAMPLE, 5, 32767, -32768);
      send(bgc_pkg::CMD_SAMPLE, 0, -32768, -32768);
      drain(12);

      // directed: unity-like mapping, gain a only
      set_mapping(0, 32'h10000, FILL_CHANNELS, 0, 32'h10000, 1024, 1);
      send(bgc_pkg::CMD_LOAD_A, 4, 16'h7fff, 16'h7fff);
      send(bgc_pkg::CMD_LOAD_A, 5, 16'h7fff, 16'h7fff);
      send(bgc_pkg::CMD_LOAD_A, 6, 16'h7fff, 16'h7fff);
      send(bgc_pkg::CMD_LOAD_A, 1024, 0, 0);
      send(bgc_pkg::CMD_LOAD_B, 65535, 0, 0);
      send(bgc_pkg::CMD_UNUSED, 5, 1, 1);
      send(bgc_pkg::CMD_SAMPLE, 5, 32767, 32767);
      send(bgc_pkg::CMD_SAMPLE, 5, -32768, -32768);
      send(bgc_pkg::CMD_SAMPLE, 5, 32767, -32768);
      send(bgc_pkg::CMD_SAMPLE, 0, 1000, -1000);
      send(bgc_pkg::CMD_SAMPLE, FILL_CHANNELS - 1, -1, 1);
      send(bgc_pkg::CMD_SAMPLE, 1024, 123, 456);
      send(bgc_pkg::CMD_SAMPLE, 65535, 0, 0);
      random_items(60, FILL_CHANNELS + 8);
      drain(12);

      // gain b only, every channel lands on the top edge of a clamped size
      set_mapping(32'hfffe0000, 32'h8000, 0, 32'h03ff0000, 0, 2047, 2);
      send(bgc_pkg::CMD_SAMPLE, 0, 32767, 32767);
      send(bgc_pkg::CMD_SAMPLE, 1, -32768, 32767);
      random_items(85, 700);
      drain(12);

      set_mapping(32'h7fffffff, 32'h10000, 2, 0, 0, 2, 3);
      write_reg(REG_UNKNOWN, 32'hffffffff);
      random_items(60, 8);
      drain(12);

      set_mapping(32'h80000000, 32'hffffffff, 1024, 32'h7fff, 32'h10000, 600, 3);
      send(bgc_pkg::CMD_SAMPLE, 0, 32767, 32767);
      random_items(60, 4);
      drain(12);

      set_mapping(32'h18000, 32'h20000, 40, 0, 32'h10000, FILL_CHANNELS, 3);
      send(bgc_pkg::CMD_SAMPLE, 0, -32768, -32768);
      send(bgc_pkg::CMD_SAMPLE, 18, 32767, -32768);
      send(bgc_pkg::CMD_SAMPLE, 19, 32767, -32768);
      random_items(100, 24);
      drain(12);

      set_mapping(0, 32'h10000, 1024, 0, 32'h10000, 1024, 0);
      random_items(60, 100);
      drain(12);

      if (errors == 0)
         $display("bandpass_gain_correction_unit: match");
      else
         $display("bandpass_gain_correction_unit: mismatch");
      $finish;
   end

endmodule
